// ===== rtl/xed_pkg.sv =====
// Shared types and constants for the XML entity decoder with UTF-8 output.
// No dependencies; every other file of the block imports this package.
package xed_pkg;

	// Longest entity body that is collected between '&' and ';'
	localparam int MAX_ENTITY_CHARS = 11;
	localparam int LEN_W = $clog2(MAX_ENTITY_CHARS + 1);

	// Highest code point a numeric reference may name
	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	// Scan modes
	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_ENTITY = 2'd1;
	localparam logic [1:0] MODE_DROP   = 2'd2;

	// Characters of interest
	localparam logic [7:0] CH_AMP  = 8'h26;  // &
	localparam logic [7:0] CH_SEMI = 8'h3B;  // ;
	localparam logic [7:0] CH_HASH = 8'h23;  // #
	localparam logic [7:0] CH_LT   = 8'h3C;  // <
	localparam logic [7:0] CH_GT   = 8'h3E;  // >
	localparam logic [7:0] CH_QUOT = 8'h22;  // "
	localparam logic [7:0] CH_APOS = 8'h27;  // '
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;

	// Input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in_string;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       error;
	} out_item_t;

	// Group of up to four results caused by one input item
	typedef struct packed {
		logic [2:0]      cnt;       // number of results, 0 to 4 (0 when none)
		logic [3:0][7:0] bytes;     // result bytes, first in bytes[0]
		logic            bvalid;    // bytes carry data (0 for an end marker)
		logic            str_end;   // final result closes the string
		logic            err;       // end marker of a malformed string
	} grp_t;

endpackage

// ===== rtl/xed_in_if.sv =====
// Input channel of the entity decoder: valid/ready with one text byte per item.
// Depends on xed_pkg.
interface xed_in_if import xed_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/xed_out_if.sv =====
// Output channel of the entity decoder: valid/ready with one result byte per item.
// Depends on xed_pkg.
interface xed_out_if import xed_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/xed_scan.sv =====
// Entity scanner: tracks text/entity/drop mode, folds numeric digits as they
// arrive and builds the group of results for each accepted item. Uses xed_pkg.
module xed_scan import xed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	xed_in_if.sink      din,
	input  logic        take_ok,
	output logic        grp_load,
	output grp_t        grp
);

	logic [1:0]       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             err_seen_q, err_seen_d;
	logic [3:0][7:0]  chars_q;
	logic             num_q, hex_q, bad_q, big_q;
	logic [3:0]       ndig_q;
	logic [20:0]      val_q;

	logic             acc;
	logic [7:0]       b;
	logic             last;
	logic             collect;

	// Name and numeric decode of the collected entity
	logic             is_amp, is_lt, is_gt, is_quot, is_apos, num_ok;
	logic [3:0][7:0]  utf_bytes;
	logic [2:0]       utf_cnt;
	logic [3:0][7:0]  dec_bytes;
	logic [2:0]       dec_cnt;

	// Digit step
	logic             is_dec, is_hex, dig_ok, is_xch;
	logic [3:0]       dval;
	logic [24:0]      nv;

	assign acc = din.valid && din.ready;
	assign din.ready = take_ok;
	assign b = din.data.in_byte;
	assign last = din.data.last_in_string;

	assign is_amp = (len_q == LEN_W'(3)) && chars_q[0] == 8'h61 && chars_q[1] == 8'h6D
		&& chars_q[2] == 8'h70;
	assign is_lt = (len_q == LEN_W'(2)) && chars_q[0] == 8'h6C && chars_q[1] == 8'h74;
	assign is_gt = (len_q == LEN_W'(2)) && chars_q[0] == 8'h67 && chars_q[1] == 8'h74;
	assign is_quot = (len_q == LEN_W'(4)) && chars_q[0] == 8'h71 && chars_q[1] == 8'h75
		&& chars_q[2] == 8'h6F && chars_q[3] == 8'h74;
	assign is_apos = (len_q == LEN_W'(4)) && chars_q[0] == 8'h61 && chars_q[1] == 8'h70
		&& chars_q[2] == 8'h6F && chars_q[3] == 8'h73;
	assign num_ok = (len_q > LEN_W'(1)) && num_q && (ndig_q != 4'd0) && (ndig_q <= 4'd8)
		&& !bad_q && !big_q;

	// UTF-8 encoding of the folded code point
	always_comb begin
		utf_bytes = '0;
		if (val_q < 21'h80) begin
			utf_cnt = 3'd1;
			utf_bytes[0] = val_q[7:0];
		end else if (val_q < 21'h800) begin
			utf_cnt = 3'd2;
			utf_bytes[0] = {3'b110, val_q[10:6]};
			utf_bytes[1] = {2'b10, val_q[5:0]};
		end else if (val_q < 21'h10000) begin
			utf_cnt = 3'd3;
			utf_bytes[0] = {4'b1110, val_q[15:12]};
			utf_bytes[1] = {2'b10, val_q[11:6]};
			utf_bytes[2] = {2'b10, val_q[5:0]};
		end else begin
			utf_cnt = 3'd4;
			utf_bytes[0] = {5'b11110, val_q[20:18]};
			utf_bytes[1] = {2'b10, val_q[17:12]};
			utf_bytes[2] = {2'b10, val_q[11:6]};
			utf_bytes[3] = {2'b10, val_q[5:0]};
		end
	end

	always_comb begin
		dec_bytes = '0;
		dec_cnt = 3'd1;
		if (is_amp) begin
			dec_bytes[0] = CH_AMP;
		end else if (is_lt) begin
			dec_bytes[0] = CH_LT;
		end else if (is_gt) begin
			dec_bytes[0] = CH_GT;
		end else if (is_quot) begin
			dec_bytes[0] = CH_QUOT;
		end else if (is_apos) begin
			dec_bytes[0] = CH_APOS;
		end else if (num_ok) begin
			dec_bytes = utf_bytes;
			dec_cnt = utf_cnt;
		end else begin
			dec_cnt = 3'd0;
		end
	end

	// Digit classification and one fold step of the running value
	assign is_dec = b inside {[8'h30:8'h39]};
	assign is_hex = is_dec || (b inside {[8'h41:8'h46], [8'h61:8'h66]});
	assign dig_ok = hex_q ? is_hex : is_dec;
	assign is_xch = (b == CH_X_LO) || (b == CH_X_UP);
	assign dval = is_dec ? b[3:0] : b[3:0] + 4'd9;
	assign nv = hex_q ? ({val_q, 4'b0000} + 25'(dval))
		: ({1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + 25'(dval));

	// Mode, length and result group
	always_comb begin
		logic fail;
		fail = 1'b0;
		collect = 1'b0;
		mode_d = mode_q;
		len_d = len_q;
		err_seen_d = err_seen_q;
		grp = '0;
		grp.bvalid = 1'b1;
		case (mode_q)
			MODE_PLAIN: begin
				if (b == CH_AMP) begin
					mode_d = MODE_ENTITY;
					len_d = '0;
				end else begin
					grp.cnt = 3'd1;
					grp.bytes[0] = b;
				end
			end
			MODE_ENTITY: begin
				if (b == CH_SEMI) begin
					if (dec_cnt == 3'd0) begin
						fail = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
						grp.cnt = dec_cnt;
						grp.bytes = dec_bytes;
					end
					len_d = '0;
				end else if (len_q >= LEN_W'(MAX_ENTITY_CHARS)) begin
					fail = 1'b1;
				end else begin
					collect = 1'b1;
					len_d = len_q + LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
		if (fail) begin
			mode_d = MODE_DROP;
			len_d = '0;
			err_seen_d = 1'b1;
			grp.cnt = 3'd0;
		end
		if (last) begin
			if (grp.cnt != 3'd0 && !err_seen_d && mode_d == MODE_PLAIN) begin
				grp.str_end = 1'b1;
			end else begin
				grp.cnt = 3'd1;
				grp.bytes = '0;
				grp.bvalid = 1'b0;
				grp.str_end = 1'b1;
				grp.err = 1'b1;
			end
			mode_d = MODE_PLAIN;
			len_d = '0;
			err_seen_d = 1'b0;
		end
	end

	assign grp_load = acc && (grp.cnt != 3'd0);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			len_q <= '0;
			err_seen_q <= 1'b0;
		end else if (acc) begin
			mode_q <= mode_d;
			len_q <= len_d;
			err_seen_q <= err_seen_d;
		end
	end

	// Collected name bytes and numeric fold; only read within the current entity
	always_ff @(posedge clk) begin
		if (acc && collect) begin
			if (len_q < LEN_W'(4)) begin
				chars_q[len_q[1:0]] <= b;
			end
			if (len_q == '0) begin
				num_q <= (b == CH_HASH);
				hex_q <= 1'b0;
				ndig_q <= 4'd0;
				bad_q <= 1'b0;
				big_q <= 1'b0;
				val_q <= '0;
			end else if (num_q) begin
				if (len_q == LEN_W'(1) && is_xch) begin
					hex_q <= 1'b1;
				end else begin
					if (!dig_ok) begin
						bad_q <= 1'b1;
					end
					if (ndig_q != 4'd9) begin
						ndig_q <= ndig_q + 4'd1;
					end
					if (nv > 25'(CP_MAX)) begin
						big_q <= 1'b1;
					end
					val_q <= nv[20:0];
				end
			end
		end
	end

endmodule

// ===== rtl/xed_emit.sv =====
// Result register: holds one group of up to four results and hands them out
// one item per cycle while the output is ready. Uses xed_pkg.
module xed_emit import xed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        grp_load,
	input  grp_t        grp,
	output logic        take_ok,
	xed_out_if.source   dout
);

	logic [2:0]      cnt_q;
	logic [1:0]      idx_q;
	logic [3:0][7:0] bytes_q;
	logic            bvalid_q, end_q, err_q;
	logic            pop;

	assign dout.valid = (cnt_q != 3'd0);
	assign pop = dout.valid && dout.ready;

	// A new group may enter once the register is empty or its final item leaves
	assign take_ok = (cnt_q == 3'd0) || (cnt_q == 3'd1 && dout.ready);

	assign dout.data.out_byte = bytes_q[idx_q];
	assign dout.data.byte_valid = bvalid_q;
	assign dout.data.string_end = end_q && (cnt_q == 3'd1);
	assign dout.data.error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (grp_load) begin
			cnt_q <= grp.cnt;
			idx_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	// Payload of the held group
	always_ff @(posedge clk) begin
		if (grp_load) begin
			bytes_q <= grp.bytes;
			bvalid_q <= grp.bvalid;
			end_q <= grp.str_end;
			err_q <= grp.err;
		end
	end

endmodule

// ===== rtl/xml_entity_decoder_utf8.sv =====
// XML character entity decoder with UTF-8 output. One text byte enters per item
// and one result byte leaves per item. Plain bytes pass through the result
// register, and a new byte is taken in every cycle while the output keeps up.
// A closing ';' of a numeric reference yields one to four UTF-8 bytes at once;
// they leave one per cycle from the result register while the output keeps
// up, and input is held until the last of them leaves, a stall that the bytes
// of the entity itself more than cover on average. A malformed entity silences
// the rest of the string, which ends in a single marker item with error set.
// Depends on xed_pkg, xed_in_if, xed_out_if, xed_scan and xed_emit.
module xml_entity_decoder_utf8 import xed_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	xed_in_if.sink      din,
	xed_out_if.source   dout
);

	logic take_ok;
	logic grp_load;
	grp_t grp;

	xed_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.take_ok  (take_ok),
		.grp_load (grp_load),
		.grp      (grp)
	);

	xed_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp_load (grp_load),
		.grp      (grp),
		.take_ok  (take_ok),
		.dout     (dout)
	);

endmodule
